// ===== sv/bsfr_pkg.sv =====
// Package for the byte-stuffed frame receiver: line constants, control-byte
// table, status codes and the structs shared by the core, the register file
// and the top level. No dependencies.
package bsfr_pkg;

  // Line bytes
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] STUFF_MASK = 8'h20;

  // Register reset values and the payload cap default
  localparam logic [7:0]  ADDR_RESET  = 8'h03;
  localparam logic [10:0] LIMIT_RESET = 11'd1000;
  localparam int          MAX_PAYLOAD_BYTES_DEF = 1024;

  // Frame kinds
  localparam logic [3:0] KIND_SET  = 4'd0;
  localparam logic [3:0] KIND_UA   = 4'd1;
  localparam logic [3:0] KIND_DISC = 4'd2;
  localparam logic [3:0] KIND_RR0  = 4'd3;
  localparam logic [3:0] KIND_RR1  = 4'd4;
  localparam logic [3:0] KIND_REJ0 = 4'd5;
  localparam logic [3:0] KIND_REJ1 = 4'd6;
  localparam logic [3:0] KIND_I0   = 4'd7;
  localparam logic [3:0] KIND_I1   = 4'd8;
  localparam int         NUM_KINDS = 9;

  // Frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BCC2_ERR = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_NO_BCC2  = 2'd3;

  // Register indexes
  localparam logic REG_ADDR  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0]  accepted_address;
    logic [10:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [3:0]  frame_kind;
    logic [1:0]  frame_status;
    logic [10:0] frame_length;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] kind;
  } ctrl_hit_t;

  // Control byte for each frame kind
  function automatic logic [7:0] ctrl_code(input logic [3:0] kind);
    logic [7:0] code;
    case (kind)
      KIND_SET:  code = 8'h03;
      KIND_UA:   code = 8'h07;
      KIND_DISC: code = 8'h0B;
      KIND_RR0:  code = 8'h05;
      KIND_RR1:  code = 8'h85;
      KIND_REJ0: code = 8'h01;
      KIND_REJ1: code = 8'h81;
      KIND_I0:   code = 8'h00;
      KIND_I1:   code = 8'h40;
      default:   code = 8'h03;
    endcase
    return code;
  endfunction

  // Classify a control byte; first match wins
  function automatic ctrl_hit_t ctrl_lookup(input logic [7:0] b);
    ctrl_hit_t r;
    r = '0;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (ctrl_code(4'(k)) == b) begin
        r.hit  = 1'b1;
        r.kind = 4'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/byte_stuffed_frame_receiver.sv =====
// Byte-stuffed frame receiver top: input register, parser core, result register
// and APB registers; depends on bsfr_pkg, bsfr_cfg and bsfr_core.
// One byte per cycle while the result is not stalled; a byte is registered in the
// input register, then its word in the result register. A stalled result holds a
// full input register and so the input. Reset (rst_ni, async, low) clears
// handshake and frame state and returns the registers to address 0x03 and limit 1000.
module byte_stuffed_frame_receiver #(
  parameter int MAX_PAYLOAD_BYTES = bsfr_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        frame_end_o,
  output logic [3:0]  frame_kind_o,
  output logic [1:0]  frame_status_o,
  output logic [10:0] frame_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              out_vld_q;
  bsfr_pkg::result_t res_q;
  bsfr_pkg::result_t res_comb;
  bsfr_pkg::cfg_t    cfg;
  logic              advance;

  bsfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsfr_core #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .result_o (res_comb)
  );

  // Move a word into the result register when it is free or being taken
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign data_valid_o   = res_q.data_valid;
  assign data_byte_o    = res_q.data_byte;
  assign frame_end_o    = res_q.frame_end;
  assign frame_kind_o   = res_q.frame_kind;
  assign frame_status_o = res_q.frame_status;
  assign frame_length_o = res_q.frame_length;

`ifndef NO_ASSERTIONS
  // Input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // A word never carries data and a frame report together
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(data_valid_o && frame_end_o))
    else $error("data and frame end in one word");

  // Report fields are zero outside a frame end
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_end_o) |->
      (frame_kind_o == 4'd0 && frame_status_o == 2'd0 && frame_length_o == 11'd0))
    else $error("report fields set without frame end");

  // Data byte is zero when no data is carried
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_valid_o) |-> (data_byte_o == 8'd0))
    else $error("data byte set without data valid");
`endif

endmodule

// ===== sv/bsfr_cfg.sv =====
// APB-style register file for the frame receiver: accepted address and
// payload limit. Depends on bsfr_pkg.
module bsfr_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bsfr_pkg::cfg_t      cfg_o
);

  logic [7:0]  addr_q;
  logic [10:0] limit_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= bsfr_pkg::ADDR_RESET;
      limit_q <= bsfr_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bsfr_pkg::REG_ADDR:  addr_q  <= pwdata[7:0];
        bsfr_pkg::REG_LIMIT: limit_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      bsfr_pkg::REG_ADDR:  prdata = {24'd0, addr_q};
      bsfr_pkg::REG_LIMIT: prdata = {21'd0, limit_q};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.accepted_address = addr_q;
  assign cfg_o.payload_limit    = limit_q;

endmodule

// ===== sv/bsfr_core.sv =====
// Frame parser of the receiver: header check, destuffing, BCC2 hold-back and
// frame reporting, one byte per step. Depends on bsfr_pkg.
module bsfr_core #(
  parameter int MAX_PAYLOAD_BYTES = bsfr_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  bsfr_pkg::cfg_t       cfg_i,
  output bsfr_pkg::result_t    result_o
);

  // The 11-bit limit register caps the count below this anyway
  localparam int LIMIT_CAP = (MAX_PAYLOAD_BYTES < 2047) ? MAX_PAYLOAD_BYTES : 2047;
  localparam int CNT_W     = $clog2(LIMIT_CAP + 1);
  localparam logic [10:0] LIMIT_CAP_V = 11'(LIMIT_CAP);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_CTRL   = 3'd2;
  localparam logic [2:0] PH_BCC1   = 3'd3;
  localparam logic [2:0] PH_SUPEND = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [3:0]       kind_q, kind_d;
  logic             esc_q, esc_d;
  logic [7:0]       held_q, held_d;
  logic             held_vld_q, held_vld_d;
  logic [7:0]       parity_q, parity_d;
  logic [CNT_W-1:0] count_q, count_d;

  bsfr_pkg::ctrl_hit_t ctrl;
  logic [7:0]          bcc1;
  logic [7:0]          cur;
  logic                have_byte;
  logic [10:0]         limit_eff;
  logic [10:0]         count_ext;
  logic [2:0]          restart;
  logic                is_flag;

  assign is_flag   = (byte_i == bsfr_pkg::FLAG_BYTE);
  assign restart   = is_flag ? PH_ADDR : PH_HUNT;
  assign ctrl      = bsfr_pkg::ctrl_lookup(byte_i);
  assign bcc1      = cfg_i.accepted_address ^ bsfr_pkg::ctrl_code(kind_q);
  assign limit_eff = (cfg_i.payload_limit > LIMIT_CAP_V) ? LIMIT_CAP_V : cfg_i.payload_limit;
  assign count_ext = 11'(count_q);

  // Step the frame state for one line byte
  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    esc_d      = esc_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    parity_d   = parity_q;
    count_d    = count_q;
    result_o   = '0;
    cur        = byte_i;
    have_byte  = 1'b0;
    case (phase_q)
      PH_ADDR: begin
        if (byte_i == cfg_i.accepted_address && !is_flag) phase_d = PH_CTRL;
        else phase_d = restart;
      end
      PH_CTRL: begin
        if (ctrl.hit) begin
          kind_d  = ctrl.kind;
          phase_d = PH_BCC1;
        end else begin
          phase_d = restart;
        end
      end
      PH_BCC1: begin
        if (byte_i == bcc1 && !is_flag) begin
          if (kind_q >= bsfr_pkg::KIND_I0) begin
            phase_d    = PH_DATA;
            esc_d      = 1'b0;
            held_d     = '0;
            held_vld_d = 1'b0;
            parity_d   = '0;
            count_d    = '0;
          end else begin
            phase_d = PH_SUPEND;
          end
        end else begin
          phase_d = restart;
        end
      end
      PH_SUPEND: begin
        if (is_flag) begin
          result_o.frame_end  = 1'b1;
          result_o.frame_kind = kind_q;
          phase_d             = PH_ADDR;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (is_flag) begin
          // Close the frame; a pending escape is discarded
          esc_d               = 1'b0;
          result_o.frame_end  = 1'b1;
          result_o.frame_kind = kind_q;
          if (held_vld_q) begin
            result_o.frame_status = (held_q == parity_q) ? bsfr_pkg::ST_OK
                                                         : bsfr_pkg::ST_BCC2_ERR;
            result_o.frame_length = count_ext;
          end else begin
            result_o.frame_status = bsfr_pkg::ST_NO_BCC2;
          end
          held_vld_d = 1'b0;
          phase_d    = PH_ADDR;
        end else if (esc_q) begin
          // Unescape; drop unknown escaped values
          esc_d = 1'b0;
          if (byte_i == (bsfr_pkg::FLAG_BYTE ^ bsfr_pkg::STUFF_MASK) ||
              byte_i == (bsfr_pkg::ESC_BYTE ^ bsfr_pkg::STUFF_MASK)) begin
            cur       = byte_i ^ bsfr_pkg::STUFF_MASK;
            have_byte = 1'b1;
          end
        end else if (byte_i == bsfr_pkg::ESC_BYTE) begin
          esc_d = 1'b1;
        end else begin
          have_byte = 1'b1;
        end
        // Release the held byte and hold the new one
        if (have_byte) begin
          if (held_vld_q && count_ext >= limit_eff) begin
            result_o.frame_end    = 1'b1;
            result_o.frame_kind   = kind_q;
            result_o.frame_status = bsfr_pkg::ST_TOO_LONG;
            result_o.frame_length = count_ext;
            held_vld_d            = 1'b0;
            phase_d               = PH_HUNT;
          end else begin
            if (held_vld_q) begin
              result_o.data_valid = 1'b1;
              result_o.data_byte  = held_q;
              parity_d            = parity_q ^ held_q;
              count_d             = count_q + 1'b1;
            end
            held_d     = cur;
            held_vld_d = 1'b1;
          end
        end
      end
      default: phase_d = restart;
    endcase
  end

  // Advance the state on each accepted step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      kind_q     <= '0;
      esc_q      <= 1'b0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      parity_q   <= '0;
      count_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      esc_q      <= esc_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      parity_q   <= parity_d;
      count_q    <= count_d;
    end
  end

endmodule

// ===== tb/tb_byte_stuffed_frame_receiver.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the byte-stuffed frame receiver: a frame tracker
// class predicts every result word and compares it with the block's output.
// Depends on bsfr_pkg and byte_stuffed_frame_receiver.
module tb_byte_stuffed_frame_receiver;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int NUM_SETTINGS   = 8;
  localparam int ITEMS_PER_SET  = 135;

  // Control byte for each frame kind, indexed by kind
  localparam logic [7:0] CTRL_TABLE [0:8] = '{
    8'h03, 8'h07, 8'h0B, 8'h05, 8'h85, 8'h01, 8'h81, 8'h00, 8'h40
  };

  // Register settings per phase; the first one is the reset state
  localparam logic [7:0]  SET_ADDR  [0:NUM_SETTINGS-1] = '{
    8'h03, 8'h03, 8'h00, 8'hFF, 8'h7E, 8'h5A, 8'h7D, 8'h03
  };
  localparam logic [10:0] SET_LIMIT [0:NUM_SETTINGS-1] = '{
    11'd1000, 11'd2, 11'd1, 11'd1024, 11'd5, 11'd0, 11'd3, 11'd2047
  };
  localparam int unsigned SEND_IDLE  [0:3] = '{0, 64, 0, 23};
  localparam int unsigned RECV_STALL [0:3] = '{0, 0, 64, 23};

  typedef enum logic [2:0] {
    SEEK_FLAG  = 3'd0,
    GET_ADDR   = 3'd1,
    GET_CTRL   = 3'd2,
    GET_BCC1   = 3'd3,
    SUPER_TAIL = 3'd4,
    PAYLOAD    = 3'd5
  } parse_state_e;

  // Frame tracker: mirrors the parser and holds the pending result words
  class frame_tracker;
    bsfr_pkg::result_t pending[$];
    logic [7:0]   accept_addr;
    logic [10:0]  limit_reg;
    parse_state_e parse_state;
    logic [3:0]   kind;
    logic         esc;
    logic [7:0]   held;
    logic         held_ok;
    logic [7:0]   parity;
    logic [10:0]  count;
    int unsigned  errors;
    int unsigned  frames_seen;
    int unsigned  data_words;
    int unsigned  words_checked;

    function new();
      accept_addr = bsfr_pkg::ADDR_RESET;
      limit_reg   = bsfr_pkg::LIMIT_RESET;
      parse_state = SEEK_FLAG;
      kind = '0; esc = 1'b0; held = '0; held_ok = 1'b0; parity = '0; count = '0;
      errors = 0; frames_seen = 0; data_words = 0; words_checked = 0;
    endfunction

    function void set_register(input logic idx, input logic [31:0] value);
      if (idx == bsfr_pkg::REG_ADDR) accept_addr = value[7:0];
      else limit_reg = value[10:0];
    endfunction

    // A flag reopens the header, anything else goes back to hunting
    function parse_state_e flag_restart(input logic [7:0] b);
      return (b == bsfr_pkg::FLAG_BYTE) ? GET_ADDR : SEEK_FLAG;
    endfunction

    function void note_byte(input logic [7:0] b_in);
      bsfr_pkg::result_t r;
      logic [7:0]  b;
      logic        keep;
      int          k;
      int unsigned lim;
      r = '0;
      b = b_in;
      case (parse_state)
        GET_ADDR: begin
          if (b == accept_addr && b != bsfr_pkg::FLAG_BYTE) parse_state = GET_CTRL;
          else parse_state = flag_restart(b);
        end
        GET_CTRL: begin
          k = -1;
          for (int i = 8; i >= 0; i--) if (CTRL_TABLE[i] == b) k = i;
          if (k >= 0) begin
            kind = 4'(k);
            parse_state = GET_BCC1;
          end else begin
            parse_state = flag_restart(b);
          end
        end
        GET_BCC1: begin
          if (b == (accept_addr ^ CTRL_TABLE[kind]) && b != bsfr_pkg::FLAG_BYTE) begin
            if (kind >= bsfr_pkg::KIND_I0) begin
              parse_state = PAYLOAD;
              esc = 1'b0; held = '0; held_ok = 1'b0; parity = '0; count = '0;
            end else begin
              parse_state = SUPER_TAIL;
            end
          end else begin
            parse_state = flag_restart(b);
          end
        end
        SUPER_TAIL: begin
          if (b == bsfr_pkg::FLAG_BYTE) begin
            r.frame_end  = 1'b1;
            r.frame_kind = kind;
            parse_state  = GET_ADDR;
          end else begin
            parse_state = SEEK_FLAG;
          end
        end
        PAYLOAD: begin
          keep = 1'b1;
          // Close on flag, strip escapes, drop unknown escaped values
          if (b == bsfr_pkg::FLAG_BYTE) begin
            esc = 1'b0;
            r.frame_end  = 1'b1;
            r.frame_kind = kind;
            if (held_ok) begin
              r.frame_status = (held == parity) ? bsfr_pkg::ST_OK : bsfr_pkg::ST_BCC2_ERR;
              r.frame_length = count;
            end else begin
              r.frame_status = bsfr_pkg::ST_NO_BCC2;
            end
            held_ok = 1'b0;
            parse_state = GET_ADDR;
            keep = 1'b0;
          end else if (esc) begin
            esc = 1'b0;
            if (b == (bsfr_pkg::FLAG_BYTE ^ bsfr_pkg::STUFF_MASK) ||
                b == (bsfr_pkg::ESC_BYTE ^ bsfr_pkg::STUFF_MASK))
              b = b ^ bsfr_pkg::STUFF_MASK;
            else keep = 1'b0;
          end else if (b == bsfr_pkg::ESC_BYTE) begin
            esc = 1'b1;
            keep = 1'b0;
          end
          // Release the held byte, or abort once the limit is reached
          if (keep && held_ok) begin
            lim = limit_reg;
            if (lim > bsfr_pkg::MAX_PAYLOAD_BYTES_DEF) lim = bsfr_pkg::MAX_PAYLOAD_BYTES_DEF;
            if (count >= lim) begin
              r.frame_end    = 1'b1;
              r.frame_kind   = kind;
              r.frame_status = bsfr_pkg::ST_TOO_LONG;
              r.frame_length = count;
              held_ok = 1'b0;
              parse_state = SEEK_FLAG;
              keep = 1'b0;
            end else begin
              r.data_valid = 1'b1;
              r.data_byte  = held;
              parity = parity ^ held;
              count  = count + 11'd1;
            end
          end
          if (keep) begin
            held = b;
            held_ok = 1'b1;
          end
        end
        default: parse_state = flag_restart(b);
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(input bsfr_pkg::result_t got);
      bsfr_pkg::result_t exp;
      words_checked++;
      if (got.frame_end) frames_seen++;
      if (got.data_valid) data_words++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with nothing pending: dv=%0d byte=%02h end=%0d",
                   $time, got.data_valid, got.data_byte, got.frame_end);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch, expected dv=%0d byte=%02h end=%0d kind=%0d st=%0d len=%0d",
                   $time, exp.data_valid, exp.data_byte, exp.frame_end, exp.frame_kind,
                   exp.frame_status, exp.frame_length);
          $display("           got      dv=%0d byte=%02h end=%0d kind=%0d st=%0d len=%0d",
                   got.data_valid, got.data_byte, got.frame_end, got.frame_kind,
                   got.frame_status, got.frame_length);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        data_valid_o;
  logic [7:0]  data_byte_o;
  logic        frame_end_o;
  logic [3:0]  frame_kind_o;
  logic [1:0]  frame_status_o;
  logic [10:0] frame_length_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker tracker;
  logic [7:0]   line_q[$];
  int unsigned  idle_pct;
  int unsigned  stall_pct;
  int unsigned  bytes_sent;
  int unsigned  quiet_cycles;

  byte_stuffed_frame_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_valid_o   (data_valid_o),
    .data_byte_o    (data_byte_o),
    .frame_end_o    (frame_end_o),
    .frame_kind_o   (frame_kind_o),
    .frame_status_o (frame_status_o),
    .frame_length_o (frame_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Check each accepted result word, then pick the next ready value
  always @(posedge clk_i) begin : result_sink
    bsfr_pkg::result_t got;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      got.data_valid   = data_valid_o;
      got.data_byte    = data_byte_o;
      got.frame_end    = frame_end_o;
      got.frame_kind   = frame_kind_o;
      got.frame_status = frame_status_o;
      got.frame_length = frame_length_o;
      tracker.check_result(got);
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Abort when neither side moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one line byte, idling at random first; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  // Drain the line queue into the block
  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void push_stuffed(input logic [7:0] b);
    if (b == bsfr_pkg::FLAG_BYTE || b == bsfr_pkg::ESC_BYTE) begin
      line_q.push_back(bsfr_pkg::ESC_BYTE);
      line_q.push_back(b ^ bsfr_pkg::STUFF_MASK);
    end else begin
      line_q.push_back(b);
    end
  endfunction

  // Payload bytes lean toward the values that need stuffing
  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(9))
      0: return bsfr_pkg::FLAG_BYTE;
      1: return bsfr_pkg::ESC_BYTE;
      2: return 8'h5E;
      3: return 8'h5D;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Append one frame, mostly well formed, sometimes with a broken header or trailer
  function automatic void add_frame();
    logic [7:0]  addr;
    logic [7:0]  ctrl;
    logic [7:0]  bcc1;
    logic [7:0]  bcc2;
    logic [7:0]  d;
    int unsigned knd;
    int unsigned len;
    int unsigned fault;
    int unsigned tail;
    knd   = $urandom_range(8);
    addr  = tracker.accept_addr;
    ctrl  = CTRL_TABLE[knd];
    fault = ($urandom_range(99) < 12) ? $urandom_range(1, 4) : 0;
    // Opening flag, shared with the previous close most of the time
    if (line_q.size() == 0 || line_q[$] != bsfr_pkg::FLAG_BYTE || $urandom_range(3) == 0)
      line_q.push_back(bsfr_pkg::FLAG_BYTE);
    if ($urandom_range(99) < 8)
      repeat ($urandom_range(1, 3)) line_q.push_back(bsfr_pkg::FLAG_BYTE);
    bcc1 = addr ^ ctrl;
    if (fault == 1) addr = addr ^ 8'($urandom_range(1, 255));
    if (fault == 2) ctrl = 8'($urandom_range(255));
    if (fault == 3) bcc1 = bcc1 ^ 8'($urandom_range(1, 255));
    line_q.push_back(addr);
    line_q.push_back(ctrl);
    line_q.push_back(bcc1);
    if (knd >= bsfr_pkg::KIND_I0) begin
      len  = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      bcc2 = '0;
      repeat (len) begin
        d = pick_payload_byte();
        push_stuffed(d);
        bcc2 = bcc2 ^ d;
        // Unknown escape that the block must drop
        if ($urandom_range(9) == 0) begin
          line_q.push_back(bsfr_pkg::ESC_BYTE);
          d = 8'($urandom_range(255));
          while (d == 8'h5E || d == 8'h5D || d == bsfr_pkg::FLAG_BYTE)
            d = 8'($urandom_range(255));
          line_q.push_back(d);
        end
      end
      tail = $urandom_range(19);
      if (tail == 1 || tail == 2) bcc2 = bcc2 ^ 8'($urandom_range(1, 255));
      if (tail != 0) push_stuffed(bcc2);
      if ($urandom_range(11) == 0) line_q.push_back(bsfr_pkg::ESC_BYTE);
    end else if (fault == 4) begin
      d = 8'($urandom_range(255));
      if (d == bsfr_pkg::FLAG_BYTE) d = 8'h00;
      line_q.push_back(d);
    end
    line_q.push_back(bsfr_pkg::FLAG_BYTE);
  endfunction

  function automatic void fill_random(input int unsigned target);
    while (line_q.size() < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
      end else begin
        add_frame();
      end
    end
  endfunction

  initial begin
    tracker      = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    bytes_sent   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        wait_drained();
        write_register(bsfr_pkg::REG_ADDR, 32'(SET_ADDR[s]));
        write_register(bsfr_pkg::REG_LIMIT, 32'(SET_LIMIT[s]));
      end
      idle_pct  = SEND_IDLE[s % 4];
      stall_pct = RECV_STALL[s % 4];
      if (s == 0) begin
        // Repeated flag and SET; I0 with an escape and good BCC2; empty I1;
        // unknown control; dropped escape plus escape before flag; UA with junk tail
        line_q = '{8'h7E, 8'h7E, 8'h03, 8'h03, 8'h00, 8'h7E,
                   8'h03, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'hFF, 8'h00, 8'h81, 8'h7E,
                   8'h03, 8'h40, 8'h43, 8'h7E,
                   8'h03, 8'h99,
                   8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h31, 8'h55, 8'h7D, 8'h7E,
                   8'h7E, 8'h03, 8'h07, 8'h04, 8'h11};
        send_line();
      end
      fill_random(ITEMS_PER_SET);
      send_line();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d line bytes across %0d register settings and four idle patterns.",
             bytes_sent, NUM_SETTINGS);
    $display("Checked %0d result words: %0d frame reports, %0d payload bytes, %0d mismatches.",
             tracker.words_checked, tracker.frames_seen, tracker.data_words, tracker.errors);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d expected result words never arrived", tracker.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
